@@ design/sfbm_pkg.sv @@
package sfbm_pkg;

  // Field widths of the pixel and result items
  localparam int CHAN_W   = 8;
  localparam int POS_W    = 12;
  localparam int SIZE_W   = 13;
  localparam int FW_W     = 13;
  localparam int COLOR_W  = 24;

  // Packed stream widths
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 80;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_COLOR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PIVOT_ENABLE = 2'd2;

  localparam logic [FW_W-1:0]    FRAME_WIDTH_RST  = 13'd256;
  localparam logic [COLOR_W-1:0] PIVOT_COLOR_RST  = 24'd0;
  localparam logic               PIVOT_ENABLE_RST = 1'b0;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // Default canvas limits
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
    logic              last;
  } pix_t;

  typedef struct packed {
    logic [FW_W-1:0]    frame_width;
    logic [COLOR_W-1:0] pivot_color;
    logic               pivot_enable;
  } cfg_t;

  typedef struct packed {
    logic              blank;
    logic [POS_W-1:0]  crop_x;
    logic [POS_W-1:0]  crop_y;
    logic [SIZE_W-1:0] crop_w;
    logic [SIZE_W-1:0] crop_h;
    logic              pivot_found;
    logic [POS_W-1:0]  pivot_x;
    logic [POS_W-1:0]  pivot_y;
    logic              pivot_error;
  } result_t;

endpackage

@@ design/sfbm_frame_stats.sv @@
module sfbm_frame_stats #(
  parameter int MAX_WIDTH  = sfbm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sfbm_pkg::DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  sfbm_pkg::pix_t    pix,
  input  sfbm_pkg::cfg_t    cfg,
  output sfbm_pkg::result_t res
);
  import sfbm_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CMPW = (CW + 1 > FW_W) ? CW + 1 : FW_W;
  localparam int RCW  = RW + 1;
  localparam int CXW  = (CW > POS_W) ? CW : POS_W;
  localparam int RXW  = (RW > POS_W) ? RW : POS_W;
  localparam int CSW  = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int RSW  = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic          any_visible, any_visible_next;
  logic [RW-1:0] top_row, top_row_next, bottom_row, bottom_row_next;
  logic [CW-1:0] left_col, left_col_next, right_col, right_col_next;
  logic          marker_seen, marker_seen_next;
  logic [CW-1:0] marker_col, marker_col_next;
  logic [RW-1:0] marker_row, marker_row_next;
  logic          marker_multiple, marker_multiple_next;

  logic [CMPW-1:0] col_inc;
  logic [RCW-1:0]  row_inc;
  logic            wrap, row_room, visible, is_marker;
  logic [CW:0]     box_w;
  logic [RW:0]     box_h;

  // Position counters: a zero width wraps every pixel, an oversized one at MAX_WIDTH
  always_comb begin
    col_inc  = CMPW'(col_count) + CMPW'(1);
    wrap     = (col_inc >= CMPW'(cfg.frame_width)) || (col_inc >= CMPW'(MAX_WIDTH));
    row_inc  = RCW'(row_count) + RCW'(1);
    row_room = row_inc < RCW'(MAX_HEIGHT);
    col_count_next = wrap ? '0 : col_inc[CW-1:0];
    row_count_next = (wrap && row_room) ? row_inc[RW-1:0] : row_count;
  end

  // Bounding box of visible pixels
  always_comb begin
    visible          = pix.alpha != '0;
    any_visible_next = any_visible;
    top_row_next     = top_row;
    bottom_row_next  = bottom_row;
    left_col_next    = left_col;
    right_col_next   = right_col;
    if (visible) begin
      any_visible_next = 1'b1;
      if (!any_visible) begin
        top_row_next    = row_count;
        bottom_row_next = row_count;
        left_col_next   = col_count;
        right_col_next  = col_count;
      end else begin
        if (row_count < top_row)    top_row_next    = row_count;
        if (row_count > bottom_row) bottom_row_next = row_count;
        if (col_count < left_col)   left_col_next   = col_count;
        if (col_count > right_col)  right_col_next  = col_count;
      end
    end
  end

  // Pivot marker: first match wins, a later one raises the error flag
  always_comb begin
    is_marker = cfg.pivot_enable && (pix.alpha == ALPHA_OPAQUE) &&
                (pix.red == cfg.pivot_color[23:16]) &&
                (pix.green == cfg.pivot_color[15:8]) &&
                (pix.blue == cfg.pivot_color[7:0]);
    marker_seen_next     = marker_seen;
    marker_col_next      = marker_col;
    marker_row_next      = marker_row;
    marker_multiple_next = marker_multiple;
    if (is_marker) begin
      if (marker_seen) begin
        marker_multiple_next = 1'b1;
      end else begin
        marker_seen_next = 1'b1;
        marker_col_next  = col_count;
        marker_row_next  = row_count;
      end
    end
  end

  // Result from the state as it stands after this pixel
  always_comb begin
    logic [CXW-1:0] x_ext;
    logic [RXW-1:0] y_ext;
    logic [CSW-1:0] w_ext;
    logic [RSW-1:0] h_ext;
    logic [CXW-1:0] px_ext;
    logic [RXW-1:0] py_ext;
    box_w  = (CW+1)'(right_col_next) - (CW+1)'(left_col_next) + (CW+1)'(1);
    box_h  = (RW+1)'(bottom_row_next) - (RW+1)'(top_row_next) + (RW+1)'(1);
    x_ext  = CXW'(left_col_next);
    y_ext  = RXW'(top_row_next);
    w_ext  = CSW'(box_w);
    h_ext  = RSW'(box_h);
    px_ext = CXW'(marker_col_next);
    py_ext = RXW'(marker_row_next);
    res.blank       = !any_visible_next;
    res.crop_x      = any_visible_next ? x_ext[POS_W-1:0] : '0;
    res.crop_y      = any_visible_next ? y_ext[POS_W-1:0] : '0;
    res.crop_w      = any_visible_next ? w_ext[SIZE_W-1:0] : '0;
    res.crop_h      = any_visible_next ? h_ext[SIZE_W-1:0] : '0;
    res.pivot_found = marker_seen_next;
    res.pivot_x     = marker_seen_next ? px_ext[POS_W-1:0] : '0;
    res.pivot_y     = marker_seen_next ? py_ext[POS_W-1:0] : '0;
    res.pivot_error = marker_multiple_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && pix.last)) begin
      col_count       <= '0;
      row_count       <= '0;
      any_visible     <= 1'b0;
      top_row         <= '0;
      bottom_row      <= '0;
      left_col        <= '0;
      right_col       <= '0;
      marker_seen     <= 1'b0;
      marker_col      <= '0;
      marker_row      <= '0;
      marker_multiple <= 1'b0;
    end else if (advance) begin
      col_count       <= col_count_next;
      row_count       <= row_count_next;
      any_visible     <= any_visible_next;
      top_row         <= top_row_next;
      bottom_row      <= bottom_row_next;
      left_col        <= left_col_next;
      right_col       <= right_col_next;
      marker_seen     <= marker_seen_next;
      marker_col      <= marker_col_next;
      marker_row      <= marker_row_next;
      marker_multiple <= marker_multiple_next;
    end
  end

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    any_visible |-> (top_row <= bottom_row && left_col <= right_col))
    else $error("bounding box corners out of order");

  a_multiple_needs_seen: assert property (@(posedge clk) disable iff (rst)
    marker_multiple |-> marker_seen)
    else $error("pivot error flagged without a first pivot");

  a_counters_in_range: assert property (@(posedge clk) disable iff (rst)
    (32'(col_count) < MAX_WIDTH) && (32'(row_count) < MAX_HEIGHT))
    else $error("position counter beyond canvas limit");

endmodule

@@ design/sprite_frame_bbox_and_marker_unit.sv @@
// Sprite frame bounding box and pivot marker unit. Feed one frame of RGBA
// pixels in raster order on the s_ stream, one item per pixel, with s_tlast on
// the final pixel of the frame. Column and row are counted internally: the
// column wraps at frame_width (0 acts as 1, values above MAX_WIDTH act as
// MAX_WIDTH) and the row stops at MAX_HEIGHT - 1. A pixel with nonzero alpha is
// visible; the unit tracks the box around all visible pixels. With
// pivot_enable set, the first pixel matching pivot_color with alpha 255 is the
// pivot, and any further match sets pivot_error. Exactly one result item per
// frame leaves on the m_ stream through the input and result registers, and
// the frame state is then cleared for the next frame. The unit takes one pixel
// per clock: an input register feeds a state update in the stats unit, and a
// result register separates it from the output, so a waiting result stalls
// the input only when the next frame's last pixel arrives.
// Write the registers (frame_width, pivot_color, pivot_enable at indexes 0, 1,
// 2) only between frames, with no pixel in flight.
module sprite_frame_bbox_and_marker_unit #(
  parameter int MAX_WIDTH  = sfbm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sfbm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                              clk,
  input  logic                              rst,
  // pixel stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic [sfbm_pkg::S_DATA_W-1:0]     s_tdata,
  input  logic                              s_tlast,
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // blank[0], crop_x[12:1], crop_y[24:13], crop_w[37:25], crop_h[50:38],
  // pivot_found[51], pivot_x[63:52], pivot_y[75:64], pivot_error[76], zero[79:77]
  output logic [sfbm_pkg::M_DATA_W-1:0]     m_tdata,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sfbm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfbm_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sfbm_pkg::*;

  cfg_t    cfg;
  pix_t    s1_pix;
  logic    s1_valid;
  logic    s1_adv;
  logic    out_free;
  result_t stats_res;
  result_t out_res;

  // Registers are always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= FRAME_WIDTH_RST;
      cfg.pivot_color  <= PIVOT_COLOR_RST;
      cfg.pivot_enable <= PIVOT_ENABLE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data[FW_W-1:0];
        CFG_PIVOT_COLOR:  cfg.pivot_color  <= cfg_data[COLOR_W-1:0];
        CFG_PIVOT_ENABLE: cfg.pivot_enable <= cfg_data[0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Handshake: a pixel in the input register moves on unless it is a last
  // pixel and the result register still holds an untaken result.
  assign out_free = !m_tvalid || m_tready;
  assign s1_adv   = s1_valid && (!s1_pix.last || out_free);
  assign s_tready = !s1_valid || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_pix.red   <= s_tdata[7:0];
      s1_pix.green <= s_tdata[15:8];
      s1_pix.blue  <= s_tdata[23:16];
      s1_pix.alpha <= s_tdata[31:24];
      s1_pix.last  <= s_tlast;
    end
  end

  sfbm_frame_stats #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stats (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_adv),
    .pix     (s1_pix),
    .cfg     (cfg),
    .res     (stats_res)
  );

  // Result register: load on a frame's last pixel, hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv && s1_pix.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pix.last) begin
      out_res <= stats_res;
    end
  end

  assign m_tdata = {3'b000, out_res.pivot_error, out_res.pivot_y, out_res.pivot_x,
                    out_res.pivot_found, out_res.crop_h, out_res.crop_w,
                    out_res.crop_y, out_res.crop_x, out_res.blank};

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_pix.last) |=> m_tvalid)
    else $error("last pixel did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && s1_pix.last) |-> out_free)
    else $error("result register overwritten before it was taken");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !s1_valid))
    else $error("pipeline not empty after reset");

endmodule
